>>> hw/rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// Stepper coil sequencer package
// Shared transaction types, command codes and register indexes.
// ----------------------------------------------------------------------------
package stc_pkg;

   localparam int unsigned CMD_W       = 2;
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned PERIOD_W    = 26;
   localparam int unsigned DRIVE_W     = 4;
   localparam int unsigned CSR_ADDR_W  = 2;
   localparam int unsigned CSR_DATA_W  = 26;

   // Command codes carried in the cmd field.
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MOVE    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_PERIOD  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_STEP    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_AUTO_RELEASE = 2'd2;

   localparam logic [PERIOD_W-1:0] STEP_PERIOD_RESET = 26'd1464;

   typedef struct packed {
      logic [PERIOD_W-1:0] step_period_us;
      logic                half_step;
      logic                auto_release;
   } stc_cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic               clockwise;
      logic [COUNT_W-1:0] step_count;
   } stc_req_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] coil_drive;
      logic               stepped;
      logic [COUNT_W-1:0] steps_remaining;
      logic               busy_res;
   } stc_rsp_type;

endpackage

>>> hw/rtl/stc_if.sv
// ----------------------------------------------------------------------------
// Stepper coil sequencer channel interfaces
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
interface stc_req_if import stc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic               clockwise;
   logic [COUNT_W-1:0] step_count;

   modport source (output valid, output cmd, output clockwise, output step_count,
                   input ready);
   modport sink   (input valid, input cmd, input clockwise, input step_count,
                   output ready);
endinterface

interface stc_rsp_if import stc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DRIVE_W-1:0] coil_drive;
   logic               stepped;
   logic [COUNT_W-1:0] steps_remaining;
   logic               busy_res;

   modport source (output valid, output coil_drive, output stepped,
                   output steps_remaining, output busy_res, input ready);
   modport sink   (input valid, input coil_drive, input stepped,
                   input steps_remaining, input busy_res, output ready);
endinterface

interface stc_csr_if import stc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

>>> hw/rtl/stc_csr_regs.sv
// ----------------------------------------------------------------------------
// Stepper coil sequencer configuration registers
// Holds step period, half-step mode and auto-release enable.
// ----------------------------------------------------------------------------
module stc_csr_regs import stc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   stc_csr_if.sink     csr_bus,
   output stc_cfg_type cfg
);

   stc_cfg_type cfg_ff;
   stc_cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.addr)
            CSR_STEP_PERIOD:  cfg_in.step_period_us = csr_bus.data[PERIOD_W-1:0];
            CSR_HALF_STEP:    cfg_in.half_step      = csr_bus.data[0];
            CSR_AUTO_RELEASE: cfg_in.auto_release   = csr_bus.data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_period_us <= STEP_PERIOD_RESET;
         cfg_ff.half_step      <= 1'b1;
         cfg_ff.auto_release   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/stc_motion_core.sv
// ----------------------------------------------------------------------------
// Stepper coil sequencer motion core
// Motion state and its combinational next-state update for one command transaction.
// ----------------------------------------------------------------------------
module stc_motion_core import stc_pkg::*; #(
   parameter int unsigned COIL_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        update,
   input  stc_req_type item,
   input  stc_cfg_type cfg,
   output stc_rsp_type result
);

   localparam int unsigned PHASE_W = $clog2(COIL_COUNT);
   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(COIL_COUNT - 1);
   localparam logic [COIL_COUNT-1:0] ONE_HOT0 = COIL_COUNT'(1);

   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [PHASE_W-1:0]    prior_ff, prior_in;
   logic                  half_wait_ff, half_wait_in;
   logic [COIL_COUNT-1:0] pattern_ff, pattern_in;
   logic                  drive_en_ff, drive_en_in;
   logic                  dir_ff, dir_in;
   logic [COUNT_W-1:0]    steps_ff, steps_in;
   logic [PERIOD_W-1:0]   elapsed_ff, elapsed_in;
   logic                  rel_pend_ff, rel_pend_in;

   logic [PERIOD_W-1:0]       elapsed_sat;
   logic [PHASE_W-1:0]        phase_next;
   logic                      step_go;
   logic [COIL_COUNT+DRIVE_W-1:0] drive_ext;

   always_comb begin
      elapsed_sat = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
      step_go     = (steps_ff != '0) && (elapsed_sat > cfg.step_period_us);
      if (dir_ff) begin
         phase_next = (phase_ff == PHASE_LAST) ? '0 : phase_ff + 1'b1;
      end else begin
         phase_next = (phase_ff == '0) ? PHASE_LAST : phase_ff - 1'b1;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      prior_in     = prior_ff;
      half_wait_in = half_wait_ff;
      pattern_in   = pattern_ff;
      drive_en_in  = drive_en_ff;
      dir_in       = dir_ff;
      steps_in     = steps_ff;
      elapsed_in   = elapsed_ff;
      rel_pend_in  = rel_pend_ff;

      case (item.cmd)
         CMD_TICK: begin
            elapsed_in = elapsed_sat;
            if (step_go) begin
               elapsed_in   = '0;
               half_wait_in = ~half_wait_ff;
               if (cfg.half_step && !half_wait_ff) begin
                  // Second half of a two-one step: drop the trailing coil.
                  pattern_in = pattern_ff & ~(ONE_HOT0 << prior_ff);
               end else begin
                  prior_in   = phase_ff;
                  phase_in   = phase_next;
                  pattern_in = pattern_ff | (ONE_HOT0 << phase_next);
                  if (cfg.half_step) begin
                     pattern_in = pattern_in | (ONE_HOT0 << phase_ff);
                  end else begin
                     pattern_in = pattern_in & ~(ONE_HOT0 << phase_ff);
                  end
               end
               drive_en_in = 1'b1;
               steps_in    = steps_ff - 1'b1;
               if (cfg.auto_release && (steps_ff == COUNT_W'(1))) begin
                  rel_pend_in = 1'b1;
               end
            end else if (rel_pend_ff && (elapsed_sat >= cfg.step_period_us)) begin
               drive_en_in = 1'b0;
               rel_pend_in = 1'b0;
            end
         end
         CMD_MOVE: begin
            steps_in = item.step_count;
            dir_in   = item.clockwise;
            if (item.step_count != '0) begin
               rel_pend_in = 1'b0;
            end
         end
         CMD_RELEASE: begin
            drive_en_in = 1'b0;
            rel_pend_in = 1'b0;
         end
         default: begin
            elapsed_in = elapsed_ff;
         end
      endcase
   end

   always_comb begin
      drive_ext              = {{DRIVE_W{1'b0}},
                                (drive_en_in ? pattern_in : {COIL_COUNT{1'b0}})};
      result.coil_drive      = drive_ext[DRIVE_W-1:0];
      result.stepped         = (item.cmd == CMD_TICK) && step_go;
      result.steps_remaining = steps_in;
      result.busy_res        = (steps_in != '0) || rel_pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         prior_ff     <= '0;
         half_wait_ff <= 1'b0;
         pattern_ff   <= '0;
         drive_en_ff  <= 1'b0;
         dir_ff       <= 1'b1;
         steps_ff     <= '0;
         elapsed_ff   <= '1;
         rel_pend_ff  <= 1'b0;
      end else if (update) begin
         phase_ff     <= phase_in;
         prior_ff     <= prior_in;
         half_wait_ff <= half_wait_in;
         pattern_ff   <= pattern_in;
         drive_en_ff  <= drive_en_in;
         dir_ff       <= dir_in;
         steps_ff     <= steps_in;
         elapsed_ff   <= elapsed_in;
         rel_pend_ff  <= rel_pend_in;
      end
   end

endmodule

>>> hw/rtl/stepper_coil_sequencer_core.sv
// ----------------------------------------------------------------------------
// Stepper coil sequencer core
// Unipolar stepper coil driver with full-step and two-one half-step modes.
// ----------------------------------------------------------------------------
// Each request transaction is a one-microsecond tick, a move command (step
// count and direction) or a release command, and every request yields exactly
// one response transaction with the coil drive, a stepped flag, the steps left
// and a busy flag. The block sustains one transaction per clock while
// responses are taken: a request is captured in an input register, the motion
// core updates its state and forms the response in a single combinational
// pass, and the response register holds it until taken. The request passes
// through the input register and its response through the response register,
// and a response not yet taken holds the input register. Throughput is set by
// the motion state, which every transaction reads and writes in its
// combinational pass. Registers are written over the csr channel, which is
// always ready, and should only be written while no response is outstanding.
module stepper_coil_sequencer_core import stc_pkg::*; #(
   parameter int unsigned COIL_COUNT = 4
) (
   input  logic     clock,
   input  logic     reset,
   stc_req_if.sink  req_bus,
   stc_rsp_if.source rsp_bus,
   stc_csr_if.sink  csr_bus
);

   stc_cfg_type cfg;
   stc_req_type in_item_ff;
   logic        in_valid_ff, in_valid_in;
   stc_rsp_type rsp_ff;
   stc_rsp_type core_rsp;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        advance;
   logic        req_take;

   // The input register moves on whenever the response register is empty or
   // its transaction is being taken this cycle.
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset; their valid flags qualify them.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.cmd        <= req_bus.cmd;
         in_item_ff.clockwise  <= req_bus.clockwise;
         in_item_ff.step_count <= req_bus.step_count;
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   stc_csr_regs u_csr_regs (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   stc_motion_core #(
      .COIL_COUNT (COIL_COUNT)
   ) u_motion_core (
      .clock  (clock),
      .reset  (reset),
      .update (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_rsp)
   );

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.coil_drive      = rsp_ff.coil_drive;
   assign rsp_bus.stepped         = rsp_ff.stepped;
   assign rsp_bus.steps_remaining = rsp_ff.steps_remaining;
   assign rsp_bus.busy_res        = rsp_ff.busy_res;

endmodule
